// ===== src/tlf_pkg.sv =====
`timescale 1ns / 1ps

package tlf_pkg;

    // Byte codes
    localparam logic [7:0] CH_NL  = 8'd10;
    localparam logic [7:0] CH_SP  = 8'd32;
    localparam logic [7:0] CH_TAB = 8'd9;

    // Configuration register indexes
    localparam logic REG_FOLD_COLUMN = 1'b0;
    localparam logic REG_TAB_WIDTH   = 1'b1;

    // Register reset values and limits
    localparam logic [6:0] FOLD_COLUMN_RST = 7'd64;
    localparam logic [4:0] TAB_WIDTH_RST   = 5'd8;
    localparam logic [6:0] COL_MAX         = 7'd127;

    typedef enum logic [1:0] {
        KIND_NL,
        KIND_SPACE,
        KIND_TAB,
        KIND_OTHER
    } kind_t;

    // One classified input byte
    typedef struct packed {
        logic [7:0] ch;
        kind_t      kind;
    } item_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FOLD,
        ST_REPLAY,
        ST_FLUSH,
        ST_CHAR
    } state_t;

    // Status from the back end
    typedef struct packed {
        logic busy;
        logic take;
    } back_stat_t;

    function automatic kind_t classify(logic [7:0] ch);
        kind_t k;
        if (ch == CH_NL)
            k = KIND_NL;
        else if (ch == CH_SP)
            k = KIND_SPACE;
        else if (ch == CH_TAB)
            k = KIND_TAB;
        else
            k = KIND_OTHER;
        return k;
    endfunction

endpackage

// ===== src/tlf_ram.sv =====
`timescale 1ns / 1ps

module tlf_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/tlf_front.sv =====
`timescale 1ns / 1ps

module tlf_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  logic [7:0]      in_char,
    output tlf_pkg::item_t  head,
    output logic            head_valid,
    input  logic            take
);

    tlf_pkg::item_t slot_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           push_fire;
    logic           take_fire;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = slot_reg[rd_ptr_reg];
    assign push_fire  = push && !full;
    assign take_fire  = take && head_valid;

    // Classify on the way in; payload needs no reset
    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            slot_reg[wr_ptr_reg] <= '{ch: in_char, kind: tlf_pkg::classify(in_char)};
        end
    end

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push_fire;
        rd_ptr_next = rd_ptr_reg ^ take_fire;
        cnt_next    = cnt_reg + {1'b0, push_fire} - {1'b0, take_fire};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== src/tlf_back.sv =====
`timescale 1ns / 1ps

module tlf_back #(
    parameter int PENDING_DEPTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_en,
    input  logic                  cfg_addr,
    input  logic [6:0]            cfg_data,
    input  tlf_pkg::item_t        head,
    input  logic                  head_valid,
    output logic                  take,
    output tlf_pkg::back_stat_t   stat,
    output logic [7:0]            out_char,
    output logic                  last_of_run,
    output logic                  empty,
    input  logic                  pop
);

    localparam int             AW  = $clog2(PENDING_DEPTH);
    localparam logic [AW-1:0]  CAP = AW'(PENDING_DEPTH - 2);

    tlf_pkg::state_t state_reg, state_next;
    logic [6:0]      fold_col_reg;
    logic [4:0]      tab_w_reg;
    logic [6:0]      column_reg, column_next;
    logic [4:0]      tab_left_reg, tab_left_next;
    logic            nb_reg, nb_next;
    logic [AW-1:0]   count_reg, count_next;
    logic [AW-1:0]   idx_reg, idx_next;
    tlf_pkg::item_t  cur_reg, cur_next;
    logic [7:0]      out_char_reg;
    logic            out_last_reg;
    logic            out_valid_reg, out_valid_next;

    logic [4:0]      eff_tab;
    logic [6:0]      limit;
    logic            need_fold;
    logic            emit_ok;
    tlf_pkg::item_t  src;
    logic            needs_flush;
    logic            last_idx;
    logic [0:0]      rd_data;
    logic            ram_we;

    logic            act_emit, act_we, act_ok;
    logic [7:0]      act_char;
    logic [6:0]      act_col;
    logic [4:0]      act_tl;
    logic            act_nb;
    logic [AW-1:0]   act_cnt;

    logic [7:0]      rep_char;
    logic [6:0]      rep_col;
    logic [4:0]      rep_tl;

    logic            emit_fire;
    logic [7:0]      emit_char;
    logic            emit_last;

    // Column add, saturating
    function automatic logic [6:0] col_add(logic [6:0] col, logic [4:0] n);
        logic [7:0] s;
        s = {1'b0, col} + {3'b000, n};
        return s[7] ? tlf_pkg::COL_MAX : s[6:0];
    endfunction

    // Tab counter after one space; wraps and reloads at zero
    function automatic logic [4:0] space_tl(logic [4:0] tl, logic [4:0] eff);
        logic [4:0] d;
        d = tl - 5'd1;
        return (d == 5'd0) ? eff : d;
    endfunction

    assign eff_tab   = (tab_w_reg == 5'd0) ? 5'd1 : tab_w_reg;
    assign limit     = (fold_col_reg == 7'd0) ? 7'd0 : fold_col_reg - 7'd1;
    assign need_fold = (column_reg >= limit);
    assign emit_ok   = !out_valid_reg || pop;
    assign src       = (state_reg == tlf_pkg::ST_IDLE) ? head : cur_reg;
    assign needs_flush = (count_reg != '0) &&
                         (src.kind == tlf_pkg::KIND_NL || src.kind == tlf_pkg::KIND_OTHER);
    assign last_idx  = ((idx_reg + AW'(1)) == count_reg);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_col_reg <= tlf_pkg::FOLD_COLUMN_RST;
            tab_w_reg    <= tlf_pkg::TAB_WIDTH_RST;
        end
        else if (cfg_en)
        begin
            unique case (cfg_addr)
                tlf_pkg::REG_FOLD_COLUMN: fold_col_reg <= cfg_data;
                tlf_pkg::REG_TAB_WIDTH:   tab_w_reg    <= cfg_data[4:0];
                default:                  fold_col_reg <= fold_col_reg;
            endcase
        end
    end

    // Pending blank kinds: 1 for tab
    tlf_ram #(
        .WIDTH (1),
        .DEPTH (PENDING_DEPTH)
    ) u_pending (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg),
        .wdata (src.kind == tlf_pkg::KIND_TAB),
        .raddr (idx_next),
        .rdata (rd_data)
    );

    // Action of the byte itself, after any fold or flush
    always_comb
    begin
        act_emit = 1'b0;
        act_we   = 1'b0;
        act_char = src.ch;
        act_col  = column_reg;
        act_tl   = tab_left_reg;
        act_nb   = nb_reg;
        act_cnt  = count_reg;
        unique case (src.kind)
            tlf_pkg::KIND_NL:
            begin
                act_emit = 1'b1;
                act_char = tlf_pkg::CH_NL;
                act_col  = 7'd0;
                act_nb   = 1'b0;
                act_tl   = eff_tab;
                act_cnt  = '0;
            end
            tlf_pkg::KIND_SPACE:
            begin
                act_emit = !nb_reg;
                if (nb_reg && count_reg < CAP)
                begin
                    act_we  = 1'b1;
                    act_cnt = count_reg + AW'(1);
                end
                act_col = col_add(column_reg, 5'd1);
                act_tl  = space_tl(tab_left_reg, eff_tab);
            end
            tlf_pkg::KIND_TAB:
            begin
                act_emit = !nb_reg;
                if (nb_reg && count_reg < CAP)
                begin
                    act_we  = 1'b1;
                    act_cnt = count_reg + AW'(1);
                end
                act_col = col_add(column_reg, tab_left_reg);
                act_tl  = eff_tab;
            end
            tlf_pkg::KIND_OTHER:
            begin
                act_emit = 1'b1;
                act_col  = col_add(column_reg, 5'd1);
                act_tl   = space_tl(tab_left_reg, eff_tab);
                act_nb   = 1'b1;
            end
            default:
            begin
                act_emit = 1'b0;
            end
        endcase
        act_ok = !act_emit || emit_ok;
    end

    // One queued blank as it comes back from memory
    always_comb
    begin
        if (rd_data[0])
        begin
            rep_char = tlf_pkg::CH_TAB;
            rep_col  = col_add(column_reg, tab_left_reg);
            rep_tl   = eff_tab;
        end
        else
        begin
            rep_char = tlf_pkg::CH_SP;
            rep_col  = col_add(column_reg, 5'd1);
            rep_tl   = space_tl(tab_left_reg, eff_tab);
        end
    end

    assign take = (state_reg == tlf_pkg::ST_IDLE) && head_valid &&
                  (need_fold || needs_flush || act_ok);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tlf_pkg::ST_IDLE:
            begin
                if (head_valid && need_fold)
                    state_next = tlf_pkg::ST_FOLD;
                else if (head_valid && needs_flush)
                    state_next = tlf_pkg::ST_FLUSH;
            end
            tlf_pkg::ST_FOLD:
            begin
                if (emit_ok)
                    state_next = (count_reg != '0) ? tlf_pkg::ST_REPLAY : tlf_pkg::ST_CHAR;
            end
            tlf_pkg::ST_REPLAY, tlf_pkg::ST_FLUSH:
            begin
                if (emit_ok && last_idx)
                    state_next = tlf_pkg::ST_CHAR;
            end
            tlf_pkg::ST_CHAR:
            begin
                if (act_ok)
                    state_next = tlf_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tlf_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and emitted bytes
    always_comb
    begin
        column_next   = column_reg;
        tab_left_next = tab_left_reg;
        nb_next       = nb_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        cur_next      = cur_reg;
        ram_we        = 1'b0;
        emit_fire     = 1'b0;
        emit_char     = act_char;
        emit_last     = 1'b1;
        unique case (state_reg)
            tlf_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    cur_next = head;
                    if (!need_fold && !needs_flush)
                    begin
                        emit_fire     = act_emit;
                        ram_we        = act_we;
                        column_next   = act_col;
                        tab_left_next = act_tl;
                        nb_next       = act_nb;
                        count_next    = act_cnt;
                    end
                end
            end
            tlf_pkg::ST_FOLD:
            begin
                if (emit_ok)
                begin
                    emit_fire     = 1'b1;
                    emit_char     = tlf_pkg::CH_NL;
                    emit_last     = 1'b0;
                    column_next   = 7'd0;
                    nb_next       = 1'b0;
                    tab_left_next = eff_tab;
                    idx_next      = '0;
                end
            end
            tlf_pkg::ST_REPLAY:
            begin
                if (emit_ok)
                begin
                    emit_fire     = 1'b1;
                    emit_char     = rep_char;
                    emit_last     = 1'b0;
                    column_next   = rep_col;
                    tab_left_next = rep_tl;
                    if (last_idx)
                    begin
                        idx_next   = '0;
                        count_next = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + AW'(1);
                    end
                end
            end
            tlf_pkg::ST_FLUSH:
            begin
                if (emit_ok)
                begin
                    emit_fire = 1'b1;
                    emit_char = rep_char;
                    emit_last = 1'b0;
                    if (last_idx)
                    begin
                        idx_next   = '0;
                        count_next = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + AW'(1);
                    end
                end
            end
            tlf_pkg::ST_CHAR:
            begin
                if (act_ok)
                begin
                    emit_fire     = act_emit;
                    ram_we        = act_we;
                    column_next   = act_col;
                    tab_left_next = act_tl;
                    nb_next       = act_nb;
                    count_next    = act_cnt;
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
        out_valid_next = (out_valid_reg && !pop) || emit_fire;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tlf_pkg::ST_IDLE;
            column_reg    <= 7'd0;
            tab_left_reg  <= tlf_pkg::TAB_WIDTH_RST;
            nb_reg        <= 1'b0;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            column_reg    <= column_next;
            tab_left_reg  <= tab_left_next;
            nb_reg        <= nb_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit_fire)
        begin
            out_char_reg <= emit_char;
            out_last_reg <= emit_last;
        end
    end

    assign out_char    = out_char_reg;
    assign last_of_run = out_last_reg;
    assign empty       = !out_valid_reg;
    assign stat        = '{busy: (state_reg != tlf_pkg::ST_IDLE), take: take};

endmodule

// ===== src/text_line_folder.sv =====
`timescale 1ns / 1ps

// Channel   Ports                           Handshake
// input     in_char                         push / full
// result    out_char, last_of_run           empty / pop
// config    cfg_addr, cfg_data              cfg_en (index 0 fold column, 1 tab width)
//
// A byte that needs no fold and no flush of queued blanks is handled in the idle state,
// so plain text flows at one byte per cycle while results are taken.
// A flush runs FLUSH, CHAR; a fold runs FOLD, REPLAY (if blanks are queued), CHAR;
// while results are taken, one byte per cycle goes into a single output register.
// Reset clears the control state; the blank queue memory needs no clearing pass.
// A stalled result side fills the two-entry input queue, then full rises.

module text_line_folder #(
    parameter int PENDING_DEPTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_char,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_char,
    output logic       last_of_run,
    input  logic       cfg_en,
    input  logic       cfg_addr,
    input  logic [6:0] cfg_data
);

    tlf_pkg::item_t      head;
    logic                head_valid;
    logic                take;
    tlf_pkg::back_stat_t stat;

    // Front end: accept and classify
    tlf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .in_char    (in_char),
        .head       (head),
        .head_valid (head_valid),
        .take       (take)
    );

    // Back end: folding sequencer
    tlf_back #(
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_en      (cfg_en),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data),
        .head        (head),
        .head_valid  (head_valid),
        .take        (take),
        .stat        (stat),
        .out_char    (out_char),
        .last_of_run (last_of_run),
        .empty       (empty),
        .pop         (pop)
    );

    // No request is taken while a fold or flush is in progress
    assert property (@(posedge clk) disable iff (!rst_n) stat.busy |-> !stat.take)
        else $error("request taken while back end busy");

    // The sequencer leaves idle only by taking a request
    assert property (@(posedge clk) disable iff (!rst_n) $rose(stat.busy) |-> $past(stat.take))
        else $error("back end went busy without a request");

    // Nothing is taken from an empty front queue
    assert property (@(posedge clk) disable iff (!rst_n) !head_valid |-> !stat.take)
        else $error("request taken from empty front queue");

endmodule
